[hdl/bxds_pkg.sv]
package bxds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_FACTOR = 16;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 16;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LW_W   = COL_W + 1;
  localparam int FAC_W  = $clog2(MAX_FACTOR) + 1;
  localparam int CNT_W  = FAC_W - 1;
  localparam int AREA_W = 2 * FAC_W;
  localparam int END_W  = COL_W + FAC_W + 2;

  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = LW_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = CFG_IDX_W'(1);

  localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = LW_W'(1024);
  localparam logic [FAC_W-1:0] FACTOR_RESET     = FAC_W'(2);

  typedef struct packed {
    logic load;
    logic acc;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/bxds_ctrl.sv]
module bxds_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bxds_pkg::dp_stat_t   stat,
  output bxds_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [bxds_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.emit ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == bxds_pkg::DCNT_W'(bxds_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/bxds_datapath.sv]
module bxds_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bxds_pkg::ctrl_cmd_t              cmd,
  output bxds_pkg::dp_stat_t               stat,
  input  logic [bxds_pkg::PIX_W-1:0]       in_pixel,
  input  logic                             in_frame_start,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bxds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bxds_pkg::PIX_W-1:0]       out_average,
  output logic [bxds_pkg::COL_W-1:0]       out_col,
  output logic [bxds_pkg::ROW_W-1:0]       out_row,
  output logic                             out_row_end
);

  localparam int PIX_W  = bxds_pkg::PIX_W;
  localparam int SUM_W  = bxds_pkg::SUM_W;
  localparam int COL_W  = bxds_pkg::COL_W;
  localparam int ROW_W  = bxds_pkg::ROW_W;
  localparam int LW_W   = bxds_pkg::LW_W;
  localparam int FAC_W  = bxds_pkg::FAC_W;
  localparam int CNT_W  = bxds_pkg::CNT_W;
  localparam int AREA_W = bxds_pkg::AREA_W;
  localparam int END_W  = bxds_pkg::END_W;

  // configuration
  logic [LW_W-1:0]  line_width_r;
  logic [FAC_W-1:0] factor_r;
  logic [LW_W-1:0]  w_eff;
  logic [FAC_W-1:0] f_eff;
  logic [AREA_W-1:0] area;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= bxds_pkg::LINE_WIDTH_RESET;
      factor_r     <= bxds_pkg::FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bxds_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata;
        bxds_pkg::CFG_FACTOR:     factor_r     <= cfg_wdata[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_r == '0) begin
      w_eff = LW_W'(1);
    end else if (line_width_r > LW_W'(bxds_pkg::MAX_WIDTH)) begin
      w_eff = LW_W'(bxds_pkg::MAX_WIDTH);
    end else begin
      w_eff = line_width_r;
    end
    if (factor_r == '0) begin
      f_eff = FAC_W'(1);
    end else if (factor_r > FAC_W'(bxds_pkg::MAX_FACTOR)) begin
      f_eff = FAC_W'(bxds_pkg::MAX_FACTOR);
    end else begin
      f_eff = factor_r;
    end
  end

  assign area = AREA_W'(f_eff) * AREA_W'(f_eff);

  // position counters
  logic [COL_W-1:0] column_pos_r, column_pos_nxt;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [CNT_W-1:0] band_row_r, band_row_nxt;
  logic [CNT_W-1:0] block_col_r, block_col_nxt;
  logic [COL_W-1:0] output_col_r, output_col_nxt;

  logic [PIX_W-1:0] pix_r;
  logic [SUM_W-1:0] rd_data_r;
  logic [SUM_W-1:0] sums_mem [bxds_pkg::MAX_WIDTH];
  logic [COL_W-1:0] rd_addr;

  logic [COL_W+FAC_W-1:0] prod;
  logic [END_W-1:0]       blk_end;
  logic                   in_range;
  logic                   row_last;
  logic                   first;
  logic [SUM_W-1:0]       sum;
  logic [FAC_W-1:0]       br_inc, bc_inc;
  logic [LW_W-1:0]        cp_inc;
  logic                   mem_we;

  assign rd_addr = in_frame_start ? '0 : output_col_r;

  assign prod     = (COL_W+FAC_W)'(output_col_r) * (COL_W+FAC_W)'(f_eff);
  assign blk_end  = END_W'(prod) + END_W'(f_eff);
  assign in_range = (blk_end <= END_W'(w_eff));
  assign row_last = ((blk_end + END_W'(f_eff)) > END_W'(w_eff));
  assign first    = (band_row_r == '0) && (block_col_r == '0);
  assign sum      = first ? SUM_W'(pix_r) : rd_data_r + SUM_W'(pix_r);
  assign br_inc   = FAC_W'(band_row_r) + FAC_W'(1);
  assign bc_inc   = FAC_W'(block_col_r) + FAC_W'(1);
  assign cp_inc   = LW_W'(column_pos_r) + LW_W'(1);
  assign mem_we   = cmd.acc && in_range;

  assign stat.emit = in_range && (br_inc >= f_eff) && (bc_inc >= f_eff);

  always_comb begin
    column_pos_nxt = cp_inc[COL_W-1:0];
    row_pos_nxt    = row_pos_r;
    band_row_nxt   = band_row_r;
    block_col_nxt  = bc_inc[CNT_W-1:0];
    output_col_nxt = output_col_r;
    if (bc_inc >= f_eff) begin
      block_col_nxt  = '0;
      output_col_nxt = output_col_r + 1'b1;
    end
    if (cp_inc >= w_eff) begin
      column_pos_nxt = '0;
      block_col_nxt  = '0;
      output_col_nxt = '0;
      if ((ROW_W+1)'(row_pos_r) + (ROW_W+1)'(1) >= (ROW_W+1)'(bxds_pkg::MAX_HEIGHT)) begin
        row_pos_nxt = '0;
      end else begin
        row_pos_nxt = row_pos_r + 1'b1;
      end
      band_row_nxt = (br_inc >= f_eff) ? '0 : br_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      row_pos_r    <= '0;
      band_row_r   <= '0;
      block_col_r  <= '0;
      output_col_r <= '0;
    end else if (cmd.load && in_frame_start) begin
      column_pos_r <= '0;
      row_pos_r    <= '0;
      band_row_r   <= '0;
      block_col_r  <= '0;
      output_col_r <= '0;
    end else if (cmd.acc) begin
      column_pos_r <= column_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      band_row_r   <= band_row_nxt;
      block_col_r  <= block_col_nxt;
      output_col_r <= output_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r     <= in_pixel;
      rd_data_r <= sums_mem[rd_addr];
    end
    if (mem_we) begin
      sums_mem[output_col_r] <= sum;
    end
  end

  // shift-subtract dividers: block sum by F*F, row by F
  logic [SUM_W-1:0]  sq_r, rq_r;
  logic [AREA_W-1:0] srem_r;
  logic [FAC_W-1:0]  rrem_r;
  logic [COL_W-1:0]  col_hold_r;
  logic              row_end_hold_r;
  logic [AREA_W:0]   s_trial, s_diff;
  logic [FAC_W:0]    r_trial, r_diff;
  logic              s_ge, r_ge;

  assign s_trial = {srem_r, sq_r[SUM_W-1]};
  assign s_diff  = s_trial - (AREA_W+1)'(area);
  assign s_ge    = (s_trial >= (AREA_W+1)'(area));
  assign r_trial = {rrem_r, rq_r[SUM_W-1]};
  assign r_diff  = r_trial - (FAC_W+1)'(f_eff);
  assign r_ge    = (r_trial >= (FAC_W+1)'(f_eff));

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sq_r           <= sum;
      srem_r         <= '0;
      rq_r           <= SUM_W'(row_pos_r);
      rrem_r         <= '0;
      col_hold_r     <= output_col_r;
      row_end_hold_r <= row_last;
    end else if (cmd.div_step) begin
      sq_r   <= {sq_r[SUM_W-2:0], s_ge};
      srem_r <= s_ge ? s_diff[AREA_W-1:0] : s_trial[AREA_W-1:0];
      rq_r   <= {rq_r[SUM_W-2:0], r_ge};
      rrem_r <= r_ge ? r_diff[FAC_W-1:0] : r_trial[FAC_W-1:0];
    end
  end

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_average_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_row_end_r;
  logic [PIX_W-1:0] avg_sat;

  assign avg_sat = (sq_r > SUM_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : sq_r[PIX_W-1:0];
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average_r <= avg_sat;
      out_col_r     <= col_hold_r;
      out_row_r     <= rq_r[ROW_W-1:0];
      out_row_end_r <= row_end_hold_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_col     = out_col_r;
  assign out_row     = out_row_r;
  assign out_row_end = out_row_end_r;

endmodule

[hdl/box_average_downscaler_unit.sv]
// channel | ports                                          | direction
// input   | in_valid in_ready in_pixel in_frame_start      | word in
// result  | out_valid out_ready out_average out_col        | word out
//         | out_row out_row_end                            |
// config  | cfg_valid cfg_ready cfg_index cfg_wdata        | word in
//
// A word without a result is read from the line store, then accumulated and
// written back. A word that closes a block goes through both of those, then
// 16 steps of the one-bit-per-cycle divider, then a load of the output
// register, which waits for as long as the output register stays full.
// Reset (rst_n low, synchronous) clears the counters and control; the line
// store is not cleared. cfg_ready is always high.
module box_average_downscaler_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bxds_pkg::PIX_W-1:0]       in_pixel,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bxds_pkg::PIX_W-1:0]       out_average,
  output logic [bxds_pkg::COL_W-1:0]       out_col,
  output logic [bxds_pkg::ROW_W-1:0]       out_row,
  output logic                             out_row_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bxds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]       cfg_wdata
);

  bxds_pkg::ctrl_cmd_t cmd;
  bxds_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  bxds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bxds_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_row_end    (out_row_end)
  );

endmodule
